### rtl/core/multi_stream_audio_queue_mixer_core_assert.svh
// Assertion macros shared by the mixer core.
`ifndef MULTI_STREAM_AUDIO_QUEUE_MIXER_CORE_ASSERT_SVH
`define MULTI_STREAM_AUDIO_QUEUE_MIXER_CORE_ASSERT_SVH

// Condition must hold in the same cycle as the trigger.
`define MSAQM_ASSERT_NOW(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Condition must hold in the cycle after the trigger.
`define MSAQM_ASSERT_NEXT(lbl, clk, rst, pre, post, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### rtl/core/msaqm_pkg.sv
// Types, sizes and codes of the multi-stream audio queue mixer.
package msaqm_pkg;

   localparam int STREAMS      = 4;
   localparam int QUEUE_DEPTH  = 8;
   localparam int SAMPLE_BITS  = 16;
   localparam int SAMPLE_WORDS = 65536;

   localparam int IDX_W   = (STREAMS > 1) ? $clog2(STREAMS) : 1;
   localparam int CNT_W   = $clog2(STREAMS + 1);
   localparam int SLOT_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int LEN_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int QADDR_W = IDX_W + SLOT_W;
   localparam int QWORDS  = 1 << QADDR_W;
   localparam int ADDR_W  = $clog2(SAMPLE_WORDS);
   localparam int SUM_W   = (ADDR_W > 18) ? ADDR_W : 18;

   localparam logic [2:0] MODE_WRITE    = 3'd0;
   localparam logic [2:0] MODE_SEGMENT  = 3'd1;
   localparam logic [2:0] MODE_CALLBACK = 3'd2;
   localparam logic [2:0] MODE_FLUSH    = 3'd3;
   localparam logic [2:0] MODE_TICK     = 3'd4;

   localparam logic [1:0] KIND_SAMPLE   = 2'd0;
   localparam logic [1:0] KIND_CALLBACK = 2'd1;
   localparam logic [1:0] KIND_ACCEPTED = 2'd2;
   localparam logic [1:0] KIND_ERROR    = 2'd3;

   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_STREAM = 2'd1;
   localparam logic [1:0] ERR_FULL   = 2'd2;

   localparam logic REG_NUM_CHANNELS = 1'b0;
   localparam logic REG_STREAM_COUNT = 1'b1;

   typedef struct packed {
      logic        is_marker;
      logic        forever_flag;
      logic [15:0] start;
      logic [15:0] frames;
      logic [15:0] repeats;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [2:0]         mode;
      logic [1:0]         stream;
      logic [15:0]        address;
      logic signed [15:0] sample_value;
      logic [15:0]        frame_count;
      logic [15:0]        repeat_count;
      logic               forever_req;
      logic [15:0]        callback_id;
   } req_type;

   typedef struct packed {
      logic [1:0]         kind;
      logic signed [15:0] sample;
      logic               channel;
      logic [15:0]        callback_id_res;
      logic [1:0]         error_code;
      logic               last;
   } rsp_type;

endpackage

### rtl/core/msaqm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module msaqm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

### rtl/core/multi_stream_audio_queue_mixer_core.sv
// Top level of the multi-stream audio queue mixer: sequencer, queues and output register.
//
// Requests enter on req_valid/req_data and are accepted when req_stall is low;
// the core stalls requests while it works on one. Results leave on
// rsp_valid/rsp_data, and the core holds a result for as long as rsp_stall is
// high, pausing its sequencer until the output register frees up.
// A sample write, enqueue or flush moves through S_CMD, which posts its one result
// once the output register is free and returns the core to idle for the next request.
// A frame tick walks the streams in use with one shared sequencer. Each pass
// skips empty streams and ends with a closing step: the marker pass reads each
// queue head and reports and drops each marker it finds there, each channel reads
// the queue head, reads sample memory and accumulates for every non-empty stream
// and then emits, and the advance pass reads and updates each non-empty stream.
// The single read ports of the queue and sample memories serialize these steps.
// The last result of each request carries last = 1.
// The csr_ port sets num_channels (address 0) and stream_count (address 4)
// and is written only while the core is idle; the core itself does not enforce this.
// Reset empties every queue, clears play positions and restores stereo with
// one stream in use. Sample memory and queue storage hold no reset value.
module multi_stream_audio_queue_mixer_core
   import msaqm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   `include "multi_stream_audio_queue_mixer_core_assert.svh"

   typedef enum logic [9:0] {
      S_IDLE    = 10'b0000000001,
      S_CMD     = 10'b0000000010,
      S_MK_RD   = 10'b0000000100,
      S_MK_CHK  = 10'b0000001000,
      S_MX_RD   = 10'b0000010000,
      S_MX_MEM  = 10'b0000100000,
      S_MX_ACC  = 10'b0001000000,
      S_MX_EMIT = 10'b0010000000,
      S_AD_RD   = 10'b0100000000,
      S_AD_UPD  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [CNT_W-1:0]       idx_ff, idx_in;
   logic                   ch_ff, ch_in;
   logic [SAMPLE_BITS-1:0] sum_ff, sum_in;
   logic [LEN_W-1:0]  len_ff  [STREAMS];
   logic [LEN_W-1:0]  len_in  [STREAMS];
   logic [LEN_W-1:0]  seg_ff  [STREAMS];
   logic [LEN_W-1:0]  seg_in  [STREAMS];
   logic [SLOT_W-1:0] head_ff [STREAMS];
   logic [SLOT_W-1:0] head_in [STREAMS];
   logic [15:0]       pos_ff  [STREAMS];
   logic [15:0]       pos_in  [STREAMS];
   logic [1:0] nch_ff;
   logic [2:0] scnt_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   logic [IDX_W-1:0]   cur;
   logic [CNT_W-1:0]   used;
   logic               idx_done, stereo, out_free, emit;
   logic [SLOT_W:0]    tail_sum;
   logic [SLOT_W-1:0]  tail, head_next;
   logic [QADDR_W-1:0] q_rd_addr, q_wr_addr;
   logic               q_wr_en;
   entry_type          q_wr_data, qe;
   logic [ENTRY_W-1:0] q_rd_data;
   logic               s_wr_en;
   logic [ADDR_W-1:0]  s_rd_addr;
   logic [SAMPLE_BITS-1:0] s_rd_data;
   logic [SUM_W-1:0]   s_addr_sum;
   logic [15:0]        pos_step, reps_next;

   assign cur       = idx_ff[IDX_W-1:0];
   assign used      = (scnt_ff > 3'(STREAMS)) ? CNT_W'(STREAMS) : CNT_W'(scnt_ff);
   assign idx_done  = idx_ff >= used;
   assign stereo    = nch_ff != 2'd1;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign qe        = entry_type'(q_rd_data);
   assign q_rd_addr = {cur, head_ff[cur]};
   assign tail_sum  = {1'b0, head_ff[cur]} + (SLOT_W + 1)'(len_ff[cur]);
   assign tail      = (tail_sum >= (SLOT_W + 1)'(QUEUE_DEPTH)) ?
                      SLOT_W'(tail_sum - (SLOT_W + 1)'(QUEUE_DEPTH)) : SLOT_W'(tail_sum);
   assign head_next = (head_ff[cur] == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : head_ff[cur] + 1'b1;
   assign pos_step  = pos_ff[cur] + 16'd1;
   assign reps_next = qe.repeats - 16'd1;

   // Frame offset doubles in stereo since channels are interleaved.
   assign s_addr_sum = SUM_W'(qe.start)
                     + (stereo ? SUM_W'({pos_ff[cur], 1'b0}) : SUM_W'(pos_ff[cur]))
                     + SUM_W'(ch_ff);
   assign s_rd_addr  = s_addr_sum[ADDR_W-1:0];

   assign req_stall  = state_ff != S_IDLE;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_STREAM_COUNT) ? {29'd0, scnt_ff} : {30'd0, nch_ff};

   msaqm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(SAMPLE_WORDS)) u_sample_ram (
      .clock  (clock),
      .wr_en  (s_wr_en),
      .wr_addr(ADDR_W'(req_ff.address)),
      .wr_data(req_ff.sample_value[SAMPLE_BITS-1:0]),
      .rd_addr(s_rd_addr),
      .rd_data(s_rd_data)
   );

   msaqm_ram #(.WIDTH(ENTRY_W), .DEPTH(QWORDS)) u_queue_ram (
      .clock  (clock),
      .wr_en  (q_wr_en),
      .wr_addr(q_wr_addr),
      .wr_data(q_wr_data),
      .rd_addr(q_rd_addr),
      .rd_data(q_rd_data)
   );

   // Sequencer: every per-stream access goes through the stream index idx_ff.
   always_comb begin
      state_in  = state_ff;
      req_in    = req_ff;
      idx_in    = idx_ff;
      ch_in     = ch_ff;
      sum_in    = sum_ff;
      len_in    = len_ff;
      seg_in    = seg_ff;
      head_in   = head_ff;
      pos_in    = pos_ff;
      emit      = 1'b0;
      rsp_in    = rsp_ff;
      s_wr_en   = 1'b0;
      q_wr_en   = 1'b0;
      q_wr_addr = {cur, tail};
      q_wr_data = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               req_in = req_data;
               idx_in = CNT_W'(req_data.stream);
               ch_in  = 1'b0;
               sum_in = '0;
               if (req_data.mode == MODE_TICK) begin
                  idx_in   = '0;
                  state_in = S_MK_RD;
               end else if (req_data.mode <= MODE_FLUSH) begin
                  state_in = S_CMD;
               end
            end
         end
         S_CMD: begin
            if (out_free) begin
               emit     = 1'b1;
               rsp_in   = '0;
               rsp_in.kind = KIND_ACCEPTED;
               rsp_in.last = 1'b1;
               state_in = S_IDLE;
               if (req_ff.mode == MODE_WRITE) begin
                  s_wr_en = 1'b1;
               end else if (idx_done) begin
                  rsp_in.kind       = KIND_ERROR;
                  rsp_in.error_code = ERR_STREAM;
               end else if (req_ff.mode == MODE_FLUSH) begin
                  len_in[cur] = '0;
                  seg_in[cur] = '0;
                  pos_in[cur] = '0;
               end else if (len_ff[cur] >= LEN_W'(QUEUE_DEPTH)) begin
                  rsp_in.kind       = KIND_ERROR;
                  rsp_in.error_code = ERR_FULL;
               end else begin
                  q_wr_en = 1'b1;
                  if (req_ff.mode == MODE_CALLBACK) begin
                     q_wr_data.is_marker = 1'b1;
                     q_wr_data.start     = req_ff.callback_id;
                  end else begin
                     q_wr_data.forever_flag = req_ff.forever_req;
                     q_wr_data.start        = req_ff.address;
                     q_wr_data.frames       = req_ff.frame_count;
                     q_wr_data.repeats      = req_ff.repeat_count;
                     seg_in[cur]            = seg_ff[cur] + 1'b1;
                  end
                  if (len_ff[cur] == '0) begin
                     pos_in[cur] = '0;
                  end
                  len_in[cur] = len_ff[cur] + 1'b1;
               end
            end
         end
         S_MK_RD: begin
            if (idx_done) begin
               idx_in   = '0;
               state_in = S_MX_RD;
            end else if (len_ff[cur] == '0) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = S_MK_CHK;
            end
         end
         S_MK_CHK: begin
            if (!qe.is_marker) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_MK_RD;
            end else if (out_free) begin
               // Report the marker and drop it, then look at the new head.
               emit   = 1'b1;
               rsp_in = '0;
               rsp_in.kind            = KIND_CALLBACK;
               rsp_in.callback_id_res = qe.start;
               head_in[cur] = head_next;
               len_in[cur]  = len_ff[cur] - 1'b1;
               pos_in[cur]  = '0;
               state_in     = S_MK_RD;
            end
         end
         S_MX_RD: begin
            if (idx_done) begin
               state_in = S_MX_EMIT;
            end else if (len_ff[cur] == '0) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = S_MX_MEM;
            end
         end
         S_MX_MEM: begin
            state_in = S_MX_ACC;
         end
         S_MX_ACC: begin
            sum_in   = sum_ff + s_rd_data;
            idx_in   = idx_ff + 1'b1;
            state_in = S_MX_RD;
         end
         S_MX_EMIT: begin
            if (out_free) begin
               emit   = 1'b1;
               rsp_in = '0;
               rsp_in.kind    = KIND_SAMPLE;
               rsp_in.sample  = 16'($signed(sum_ff));
               rsp_in.channel = ch_ff;
               rsp_in.last    = !stereo || ch_ff;
               idx_in = '0;
               sum_in = '0;
               if (!stereo || ch_ff) begin
                  state_in = S_AD_RD;
               end else begin
                  ch_in    = 1'b1;
                  state_in = S_MX_RD;
               end
            end
         end
         S_AD_RD: begin
            if (idx_done) begin
               state_in = S_IDLE;
            end else if (len_ff[cur] == '0) begin
               idx_in = idx_ff + 1'b1;
            end else begin
               state_in = S_AD_UPD;
            end
         end
         S_AD_UPD: begin
            idx_in   = idx_ff + 1'b1;
            state_in = S_AD_RD;
            if (pos_step != qe.frames) begin
               pos_in[cur] = pos_step;
            end else begin
               pos_in[cur] = '0;
               if (qe.forever_flag) begin
                  // A looping segment leaves once another segment waits behind it.
                  if (seg_ff[cur] > LEN_W'(1)) begin
                     head_in[cur] = head_next;
                     len_in[cur]  = len_ff[cur] - 1'b1;
                     seg_in[cur]  = seg_ff[cur] - 1'b1;
                  end
               end else if (reps_next == '0) begin
                  head_in[cur] = head_next;
                  len_in[cur]  = len_ff[cur] - 1'b1;
                  seg_in[cur]  = seg_ff[cur] - 1'b1;
               end else begin
                  q_wr_en           = 1'b1;
                  q_wr_addr         = q_rd_addr;
                  q_wr_data         = qe;
                  q_wr_data.repeats = reps_next;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         nch_ff       <= 2'd2;
         scnt_ff      <= 3'd1;
         for (int i = 0; i < STREAMS; i++) begin
            len_ff[i]  <= '0;
            seg_ff[i]  <= '0;
            head_ff[i] <= '0;
            pos_ff[i]  <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         len_ff       <= len_in;
         seg_ff       <= seg_in;
         head_ff      <= head_in;
         pos_ff       <= pos_in;
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr[2] == REG_NUM_CHANNELS) begin
               nch_ff <= csr_pwdata[1:0];
            end else begin
               scnt_ff <= csr_pwdata[2:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      idx_ff <= idx_in;
      ch_ff  <= ch_in;
      sum_ff <= sum_in;
      rsp_ff <= rsp_in;
   end

   // A result left waiting while the core is idle must close its request.
   `MSAQM_ASSERT_NOW(a_idle_out_last, clock, reset, (state_ff == S_IDLE) && rsp_valid_ff, rsp_ff.last, "non-final result pending while idle")
   // Segment count in queue 0 never exceeds its length.
   `MSAQM_ASSERT_NOW(a_seg_le_len, clock, reset, 1'b1, seg_ff[0] <= len_ff[0], "segment count above queue length")
   // Length of queue 0 never exceeds the queue depth.
   `MSAQM_ASSERT_NOW(a_len_bound, clock, reset, 1'b1, len_ff[0] <= LEN_W'(QUEUE_DEPTH), "queue length above depth")
   // An emitted result stays posted while the receiver stalls.
   `MSAQM_ASSERT_NEXT(a_emit_held, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff && $stable(rsp_ff), "stalled result changed")

endmodule
